// ===== rtl/palmdoc_lz77_decompressor_unit_defines.svh =====
// Assertion macros for the file that checks its own logic.
`ifndef PALMDOC_LZ77_DECOMPRESSOR_UNIT_DEFINES_SVH
`define PALMDOC_LZ77_DECOMPRESSOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDLZ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdlz: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PDLZ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdlz: next-cycle check failed");

`endif

// ===== rtl/pdlz_pkg.sv =====
package pdlz_pkg;

	localparam int HISTORY_DEPTH = 2048;
	localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
	localparam int DIST_W        = 11;

	localparam logic [7:0] CNT_LO     = 8'h01;
	localparam logic [7:0] CNT_HI     = 8'h08;
	localparam logic [7:0] PAIR_LO    = 8'h80;
	localparam logic [7:0] PAIR_HI    = 8'hBF;
	localparam logic [7:0] SPACE_LO   = 8'hC0;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] FLIP_MASK  = 8'h80;

	// What an incoming byte causes, given the current decoder state.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_LIT,
		KIND_SPACE,
		KIND_COPY
	} pdlz_kind_t;

	typedef enum logic [1:0] {
		SEL_SPACE,
		SEL_LIT,
		SEL_HIST
	} pdlz_sel_t;

	typedef struct packed {
		logic      load;
		logic      emit;
		pdlz_sel_t sel;
		logic      last;
		logic      rd;
	} pdlz_cmd_t;

	typedef struct packed {
		pdlz_kind_t kind;
		logic       out_space;
		logic       rem_zero;
	} pdlz_sts_t;

endpackage

// ===== rtl/pdlz_if.sv =====
interface pdlz_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] comp_byte;
	logic       record_end;

	modport source (output valid, output comp_byte, output record_end, input ready);
	modport sink (input valid, input comp_byte, input record_end, output ready);
endinterface

interface pdlz_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/pdlz_ctrl.sv =====
module pdlz_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pdlz_pkg::pdlz_sts_t sts,
	output pdlz_pkg::pdlz_cmd_t cmd
);
	import pdlz_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SPACE = 5'b00010,
		ST_LIT   = 5'b00100,
		ST_RD    = 5'b01000,
		ST_WR    = 5'b10000
	} pdlz_state_t;

	pdlz_state_t state_q;
	pdlz_state_t state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.sel  = SEL_LIT;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (sts.kind)
						KIND_LIT:   state_d = ST_LIT;
						KIND_SPACE: state_d = ST_SPACE;
						KIND_COPY:  state_d = ST_RD;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_SPACE: begin
				cmd.sel = SEL_SPACE;
				if (sts.out_space) begin
					cmd.emit = 1'b1;
					state_d  = ST_LIT;
				end
			end
			ST_LIT: begin
				cmd.last = 1'b1;
				if (sts.out_space) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.sel  = SEL_HIST;
				cmd.last = sts.rem_zero;
				if (sts.out_space) begin
					cmd.emit = 1'b1;
					state_d  = sts.rem_zero ? ST_IDLE : ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/pdlz_dpath.sv =====
module pdlz_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          comp_byte,
	input  logic                record_end,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                run_last,
	input  pdlz_pkg::pdlz_cmd_t cmd,
	output pdlz_pkg::pdlz_sts_t sts
);
	import pdlz_pkg::*;

	typedef logic [HIST_AW:0] hist_ext_t;

	logic [7:0]         hist_mem [HISTORY_DEPTH];

	logic [HIST_AW-1:0] pos_q;
	logic               full_q;
	logic [3:0]         raw_q;
	logic               pend_q;
	logic [5:0]         high_q;
	logic [3:0]         rem_q;
	logic               out_valid_q;

	logic [7:0]         lit_q;
	logic               last_q;
	logic [DIST_W-1:0]  dist_q;
	logic [7:0]         rd_data_q;
	logic               src_ok_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic               is_count;
	logic               is_pair1;
	pdlz_kind_t         kind;
	hist_ext_t          pos_ext;
	hist_ext_t          dist_ext;
	hist_ext_t          src_ext;
	logic [HIST_AW-1:0] src_addr;
	logic               src_ok;
	logic [7:0]         emit_val;

	// Decode of the byte on the input channel against the current state.
	always_comb begin
		is_count = 1'b0;
		is_pair1 = 1'b0;
		if (pend_q) begin
			kind = KIND_COPY;
		end else if (raw_q != '0) begin
			kind = KIND_LIT;
		end else if (comp_byte inside {[CNT_LO:CNT_HI]}) begin
			kind     = KIND_NONE;
			is_count = 1'b1;
		end else if (comp_byte inside {[PAIR_LO:PAIR_HI]}) begin
			kind     = KIND_NONE;
			is_pair1 = 1'b1;
		end else if (comp_byte >= SPACE_LO) begin
			kind = KIND_SPACE;
		end else begin
			kind = KIND_LIT;
		end
	end

	// Copy source: the position the distance points back to, wrapped round the history.
	always_comb begin
		pos_ext  = {1'b0, pos_q};
		dist_ext = hist_ext_t'(dist_q);
		if (pos_ext >= dist_ext) begin
			src_ext = pos_ext - dist_ext;
		end else begin
			src_ext = pos_ext + hist_ext_t'(HISTORY_DEPTH) - dist_ext;
		end
		src_addr = src_ext[HIST_AW-1:0];
		src_ok   = (dist_q != '0) && (full_q || (pos_ext >= dist_ext));
	end

	always_comb begin
		case (cmd.sel)
			SEL_SPACE: emit_val = SPACE_CHAR;
			SEL_LIT:   emit_val = lit_q;
			SEL_HIST:  emit_val = src_ok_q ? rd_data_q : 8'h00;
			default:   emit_val = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hist_mem[pos_q] <= emit_val;
		end
		if (cmd.rd) begin
			rd_data_q <= hist_mem[src_addr];
			src_ok_q  <= src_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lit_q  <= (kind == KIND_SPACE) ? (comp_byte ^ FLIP_MASK) : comp_byte;
			last_q <= record_end;
			if (pend_q) begin
				dist_q <= {high_q, comp_byte[7:3]};
			end
		end
		if (cmd.emit) begin
			out_byte_q <= emit_val;
			out_last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			full_q      <= 1'b0;
			raw_q       <= '0;
			pend_q      <= 1'b0;
			high_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (pend_q) begin
					rem_q <= {1'b0, comp_byte[2:0]} + 4'd2;
				end
				// The end of a record cuts short a raw run and drops a half pair.
				if (record_end) begin
					raw_q  <= '0;
					pend_q <= 1'b0;
					high_q <= '0;
					if (kind == KIND_NONE) begin
						pos_q  <= '0;
						full_q <= 1'b0;
					end
				end else if (pend_q) begin
					pend_q <= 1'b0;
				end else if (raw_q != '0) begin
					raw_q <= raw_q - 4'd1;
				end else if (is_count) begin
					raw_q <= comp_byte[3:0];
				end else if (is_pair1) begin
					high_q <= comp_byte[5:0];
					pend_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				if (cmd.sel == SEL_HIST) begin
					rem_q <= rem_q - 4'd1;
				end
				if (cmd.last && last_q) begin
					pos_q  <= '0;
					full_q <= 1'b0;
				end else if (pos_q == HIST_AW'(HISTORY_DEPTH - 1)) begin
					pos_q  <= '0;
					full_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.kind      = kind;
	assign sts.out_space = !out_valid_q || out_ready;
	assign sts.rem_zero  = (rem_q == '0);

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = out_last_q;

endmodule

// ===== rtl/palmdoc_lz77_decompressor_unit.sv =====
// Channel   Role    Payload
// comp      sink    comp_byte[7:0], record_end
// decomp    source  out_byte[7:0], run_last
//
// A literal or raw byte is loaded and emitted; a 0xC0..0xFF byte first emits
// a space; a count byte or the first byte of a pair is only loaded; the second
// byte of a pair copies 3 to 10 bytes, each one history RAM read and one write.
// Reset clears the controller, position and run state at once; no RAM sweep.
// Output is a single register; a stalled decomp holds the controller in place.
`include "palmdoc_lz77_decompressor_unit_defines.svh"

module palmdoc_lz77_decompressor_unit (
	input logic         clk,
	input logic         arst_n,
	pdlz_in_if.sink     comp,
	pdlz_out_if.source  decomp
);
	import pdlz_pkg::*;

	pdlz_cmd_t cmd;
	pdlz_sts_t sts;

	pdlz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (comp.valid),
		.in_ready (comp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pdlz_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.comp_byte  (comp.comp_byte),
		.record_end (comp.record_end),
		.out_ready  (decomp.ready),
		.out_valid  (decomp.valid),
		.out_byte   (decomp.out_byte),
		.run_last   (decomp.run_last),
		.cmd        (cmd),
		.sts        (sts)
	);

	// A new byte never overwrites one that has not yet been transferred.
	`PDLZ_ASSERT_IMP(a_no_overwrite, cmd.emit, !decomp.valid || decomp.ready)

	// The second byte of a pair starts a history read in the next cycle.
	`PDLZ_ASSERT_NEXT(a_copy_reads, comp.valid && comp.ready && sts.kind == KIND_COPY, cmd.rd)

	// Each history read is followed by its write cycle, never by another read.
	`PDLZ_ASSERT_NEXT(a_read_alternates, cmd.rd, !cmd.rd && !comp.ready)

	// The closing byte of an item appears on the output flagged as such.
	`PDLZ_ASSERT_NEXT(a_last_flag, cmd.emit && cmd.last, decomp.valid && decomp.run_last)

endmodule
